### rtl/dct_pkg.sv
package dct_pkg;

    localparam int QUEUE_DEPTH = 2;

    // residue codes
    localparam logic [4:0] RES_MET   = 5'd0;
    localparam logic [4:0] RES_OCHRE = 5'd2;
    localparam logic [4:0] RES_OPAL  = 5'd4;
    localparam logic [4:0] RES_MAX   = 5'd22;

    // base codes
    localparam logic [1:0] BASE_U = 2'd0;
    localparam logic [1:0] BASE_C = 2'd1;
    localparam logic [1:0] BASE_A = 2'd2;
    localparam logic [1:0] BASE_G = 2'd3;

    // indexed by first*16 + second*4 + third
    localparam logic [4:0] CODON_TABLE [64] = '{
        5'd5,  5'd5,  5'd20, 5'd20, 5'd21, 5'd21, 5'd21, 5'd21,
        5'd6,  5'd6,  5'd2,  5'd3,  5'd13, 5'd13, 5'd4,  5'd1,
        5'd20, 5'd20, 5'd20, 5'd20, 5'd16, 5'd16, 5'd16, 5'd16,
        5'd7,  5'd7,  5'd8,  5'd8,  5'd22, 5'd22, 5'd22, 5'd22,
        5'd14, 5'd14, 5'd14, 5'd0,  5'd17, 5'd17, 5'd17, 5'd17,
        5'd9,  5'd9,  5'd10, 5'd10, 5'd21, 5'd21, 5'd22, 5'd22,
        5'd15, 5'd15, 5'd15, 5'd15, 5'd18, 5'd18, 5'd18, 5'd18,
        5'd11, 5'd11, 5'd12, 5'd12, 5'd19, 5'd19, 5'd19, 5'd19
    };

    typedef struct packed {
        logic       is_base;
        logic [1:0] base;
        logic       last;
    } base_item_t;

    function automatic logic residue_is_stop(input logic [4:0] r);
        return (r >= RES_OCHRE) && (r <= RES_OPAL);
    endfunction

endpackage

### rtl/dct_front.sv
module dct_front
    import dct_pkg::*;
(
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // char_code
    input  logic       s_tlast,   // end_of_strand
    output logic       push,
    output base_item_t push_item,
    input  logic       queue_full
);

    logic       is_base;
    logic [1:0] base;

    always_comb begin
        is_base = 1'b1;
        base    = BASE_U;
        case (s_tdata)
            8'h55, 8'h75, 8'h54, 8'h74: base = BASE_U;
            8'h43, 8'h63:               base = BASE_C;
            8'h41, 8'h61:               base = BASE_A;
            8'h47, 8'h67:               base = BASE_G;
            default:                    is_base = 1'b0;
        endcase
    end

    assign s_tready = !queue_full;

    // a non-base item without end marker has no effect and is dropped here
    assign push              = s_tvalid && s_tready && (is_base || s_tlast);
    assign push_item.is_base = is_base;
    assign push_item.base    = base;
    assign push_item.last    = s_tlast;

endmodule

### rtl/dct_queue.sv
module dct_queue
    import dct_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       push,
    input  base_item_t push_item,
    output logic       full,
    input  logic       pop,
    output logic       not_empty,
    output base_item_t pop_item
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    base_item_t       slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full      = (count_reg == FULL_CNT);
    assign not_empty = (count_reg != '0);
    assign pop_item  = slot_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

### rtl/dct_back.sv
module dct_back
    import dct_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       not_empty,
    input  base_item_t pop_item,
    output logic       pop,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // residue, zero fill
    output logic       m_tuser    // is_stop
);

    logic [1:0] phase_reg, phase_next;
    logic [3:0] bases_reg, bases_next;
    logic       out_valid_reg, out_valid_next;
    logic [4:0] residue_reg;
    logic       stop_reg;
    logic       emit;
    logic [4:0] residue;

    assign pop     = not_empty && (!out_valid_reg || m_tready);
    // phase three behaves like two
    assign emit    = pop && pop_item.is_base && phase_reg[1];
    assign residue = CODON_TABLE[{bases_reg, pop_item.base}];

    always_comb begin
        phase_next = phase_reg;
        bases_next = bases_reg;
        if (pop && pop_item.is_base) begin
            if (phase_reg[1]) begin
                phase_next = '0;
                bases_next = '0;
            end else begin
                phase_next = phase_reg + 1'b1;
                bases_next = {bases_reg[1:0], pop_item.base};
            end
        end
        if (pop && pop_item.last) begin
            phase_next = '0;
            bases_next = '0;
        end
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (emit) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= '0;
            bases_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            phase_reg     <= phase_next;
            bases_reg     <= bases_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            residue_reg <= residue;
            stop_reg    <= residue_is_stop(residue);
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'b000, residue_reg};
    assign m_tuser  = stop_reg;

endmodule

### rtl/dna_codon_translator.sv
// a codon result appears on m_tvalid after the edge that accepts its third base, by way of
// the queue write and then the lookup into the output register
// throughput: one item per cycle while m_tready does not hold the output, set by the table lookup stage
// s_tready drops only while the item queue is full
// reset: synchronous active-low aresetn clears queue, codon phase and output valid
module dna_codon_translator
    import dct_pkg::*;
#(
    parameter int QUEUE_DEPTH_P = QUEUE_DEPTH
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // char_code
    input  logic       s_tlast,   // end_of_strand
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // residue, zero fill
    output logic       m_tuser    // is_stop
);

    logic       push;
    logic       pop;
    logic       queue_full;
    logic       not_empty;
    base_item_t push_item;
    base_item_t pop_item;

    dct_front u_front (
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .push       (push),
        .push_item  (push_item),
        .queue_full (queue_full)
    );

    dct_queue #(
        .DEPTH (QUEUE_DEPTH_P)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_item (push_item),
        .full      (queue_full),
        .pop       (pop),
        .not_empty (not_empty),
        .pop_item  (pop_item)
    );

    dct_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .not_empty (not_empty),
        .pop_item  (pop_item),
        .pop       (pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule

### rtl/dct_checker.sv
module dct_checker
    import dct_pkg::*;
(
    input logic       aclk,
    input logic       aresetn,
    input logic       s_tvalid,
    input logic       s_tready,
    input logic [7:0] s_tdata,
    input logic       s_tlast,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic       m_tuser
);

    // held result must not change while stalled
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    // stop flag agrees with the residue code
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tuser == ((m_tdata[4:0] >= RES_OCHRE) && (m_tdata[4:0] <= RES_OPAL))))
        else $error("stop flag does not match residue");

    // residue stays within the code range and the fill bits are zero
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[7:5] == 3'b000) && (m_tdata[4:0] <= RES_MAX))
        else $error("residue out of range");

    // no result directly after reset
    assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind dna_codon_translator dct_checker u_dct_checker (.*);

### tb/tb.sv
`timescale 1ns / 1ps

module tb;
    import dct_pkg::*;

    typedef enum logic [4:0] {
        AA_MET, AA_TRP, AA_OCHRE, AA_AMBER, AA_OPAL, AA_PHE, AA_TYR, AA_HIS,
        AA_GLN, AA_ASN, AA_LYS, AA_ASP, AA_GLU, AA_CYS, AA_ILE, AA_VAL,
        AA_PRO, AA_THR, AA_ALA, AA_GLY, AA_LEU, AA_SER, AA_ARG
    } residue_e;

    typedef struct packed {
        residue_e residue;
        logic     is_stop;
    } residue_item_t;

    // standard genetic code, index {first, second, third} with U=0 C=1 A=2 G=3
    localparam residue_e GENETIC_CODE [64] = '{
        AA_PHE, AA_PHE, AA_LEU, AA_LEU,     AA_SER, AA_SER, AA_SER, AA_SER,
        AA_TYR, AA_TYR, AA_OCHRE, AA_AMBER, AA_CYS, AA_CYS, AA_OPAL, AA_TRP,
        AA_LEU, AA_LEU, AA_LEU, AA_LEU,     AA_PRO, AA_PRO, AA_PRO, AA_PRO,
        AA_HIS, AA_HIS, AA_GLN, AA_GLN,     AA_ARG, AA_ARG, AA_ARG, AA_ARG,
        AA_ILE, AA_ILE, AA_ILE, AA_MET,     AA_THR, AA_THR, AA_THR, AA_THR,
        AA_ASN, AA_ASN, AA_LYS, AA_LYS,     AA_SER, AA_SER, AA_ARG, AA_ARG,
        AA_VAL, AA_VAL, AA_VAL, AA_VAL,     AA_ALA, AA_ALA, AA_ALA, AA_ALA,
        AA_ASP, AA_ASP, AA_GLU, AA_GLU,     AA_GLY, AA_GLY, AA_GLY, AA_GLY
    };

    class codon_tracker;
        logic [1:0]    codon_phase;
        logic [3:0]    held_bases;
        residue_item_t expected_residues[$];
        int            mismatch_count;

        function new();
            codon_phase    = 2'd0;
            held_bases     = 4'd0;
            mismatch_count = 0;
        endfunction

        function void note_char(input logic [7:0] ch, input logic last);
            logic [1:0]    base;
            logic          is_base;
            residue_item_t res;
            is_base = 1'b1;
            base    = BASE_U;
            case (ch)
                "U", "u", "T", "t": base = BASE_U;
                "C", "c":           base = BASE_C;
                "A", "a":           base = BASE_A;
                "G", "g":           base = BASE_G;
                default:            is_base = 1'b0;
            endcase
            if (is_base) begin
                // phase three cannot occur but would act like two
                if (codon_phase >= 2'd2) begin
                    res.residue = GENETIC_CODE[{held_bases, base}];
                    res.is_stop = (res.residue == AA_OCHRE) || (res.residue == AA_AMBER) ||
                                  (res.residue == AA_OPAL);
                    expected_residues.push_back(res);
                    codon_phase = 2'd0;
                    held_bases  = 4'd0;
                end else begin
                    held_bases  = {held_bases[1:0], base};
                    codon_phase = codon_phase + 2'd1;
                end
            end
            if (last) begin
                codon_phase = 2'd0;
                held_bases  = 4'd0;
            end
        endfunction

        function void check_residue(input logic [7:0] data, input logic stop);
            residue_item_t exp_res;
            if (expected_residues.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("mismatch: unexpected residue item data=%0d stop=%0b",
                             data, stop);
                return;
            end
            exp_res = expected_residues.pop_front();
            if (data !== {3'b000, exp_res.residue} || stop !== exp_res.is_stop) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("mismatch: residue expected %0d got %0d, stop expected %0b got %0b",
                             exp_res.residue, data, exp_res.is_stop, stop);
            end
        endfunction
    endclass

    logic       aclk = 1'b0;
    logic       aresetn;
    logic       s_tvalid;
    logic       s_tready;
    logic [7:0] s_tdata;
    logic       s_tlast;
    logic       m_tvalid;
    logic       m_tready;
    logic [7:0] m_tdata;
    logic       m_tuser;

    codon_tracker tracker = new();
    bit           no_idle    = 1'b0;
    bit           hold_sink  = 1'b0;
    int           item_count = 0;

    dna_codon_translator u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // result monitor
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            tracker.check_residue(m_tdata, m_tuser);
    end

    // receiver: random stall per item, plus one long hold-off on request
    initial begin
        int stall;
        m_tready = 1'b0;
        @(posedge aclk iff aresetn);
        forever begin
            if (hold_sink) begin
                m_tready <= 1'b0;
                repeat (60) @(posedge aclk);
                hold_sink = 1'b0;
            end
            stall = no_idle ? 0 : $urandom_range(0, 5);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
        end
    end

    task automatic send_char(input logic [7:0] ch, input logic last);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 5);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= ch;
        s_tlast  <= last;
        do @(posedge aclk); while (!s_tready);
        tracker.note_char(ch, last);
    endtask

    task automatic send_text(input string txt, input logic last_on_end);
        for (int i = 0; i < txt.len(); i++)
            send_char(txt[i], last_on_end && (i == txt.len() - 1));
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (tracker.expected_residues.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    function automatic logic [7:0] random_base_char();
        string spellings [4] = '{"UuTt", "Cc", "Aa", "Gg"};
        int    b;
        b = $urandom_range(0, 3);
        return spellings[b][$urandom_range(0, spellings[b].len() - 1)];
    endfunction

    initial begin
        int         strand_len;
        logic [7:0] ch;
        logic       last;
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = 8'h00;
        s_tlast  = 1'b0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // start, all three stops, case folding, t read as u
        send_text("AUGUAAUAGUGA", 1'b1);
        send_text("tggCcC", 1'b0);
        send_char(8'h00, 1'b0);
        send_char(8'hFF, 1'b0);
        // non-base inside a codon is skipped, end marker on non-base drops partial
        send_text("Gx", 1'b0);
        send_char(8'h80, 1'b1);
        // end marker on the completing base still emits
        send_text("GGa", 1'b1);
        // end marker on a partial codon drops it
        send_text("AC", 1'b1);
        send_text("uuu", 1'b0);
        wait_drained();

        // receiver holds off while the sender streams, so the input stalls
        hold_sink = 1'b1;
        no_idle   = 1'b1;
        for (int i = 0; i < 30; i++)
            send_char(random_base_char(), 1'b0);
        no_idle = 1'b0;
        wait_drained();

        // random strands: mostly bases, some noise, end markers mostly at the tail
        while (item_count < 540) begin
            strand_len = $urandom_range(1, 30);
            no_idle    = ($urandom_range(0, 5) == 0);
            for (int i = 0; i < strand_len; i++) begin
                if ($urandom_range(0, 99) < 10)
                    ch = 8'($urandom_range(0, 255));
                else
                    ch = random_base_char();
                last = (i == strand_len - 1) ? ($urandom_range(0, 3) != 0)
                                             : ($urandom_range(0, 49) == 0);
                item_count++;
                send_char(ch, last);
            end
            if ($urandom_range(0, 9) == 0)
                wait_drained();
        end
        no_idle = 1'b0;
        wait_drained();
        repeat (10) @(posedge aclk);

        if (tracker.mismatch_count == 0 && tracker.expected_residues.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule
